FILE: hw/rtl/tpss_pkg.sv
package tpss_pkg;

  // Field widths of the item and result ports
  localparam int KIND_W   = 3;
  localparam int VM_ID_W  = 3;
  localparam int VCPU_W   = 2;
  localparam int TIMER_W  = 32;
  localparam int VCOUNT_W = 3;

  // Default sizes of the tables
  localparam int NUM_VMS_DEF      = 8;
  localparam int VCPUS_PER_VM_DEF = 4;
  localparam int SLOT_DEPTH_DEF   = 32;

  localparam logic [TIMER_W-1:0] DEFAULT_SLICE_US  = 32'd1000;
  localparam logic [TIMER_W-1:0] MAJOR_FRAME_RESET = 32'd10000;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_SLOT  = 3'd0,
    KIND_VM_STATUS = 3'd1,
    KIND_VCPU_STOP = 3'd2,
    KIND_TICK      = 3'd3,
    KIND_START     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // One entry of the slot table memory
  typedef struct packed {
    logic [VM_ID_W-1:0] vm;
    logic [VCPU_W-1:0]  vcpu;
    logic [TIMER_W-1:0] dur;
  } slot_t;

endpackage

FILE: hw/rtl/time_partition_slot_scheduler.sv
// Cyclic time-partition slot scheduler.
// Input channel (in_valid_i / in_stall_o) carries one item per transfer: add slot,
// set VM status, set vCPU stopped, tick or start. Add and status items give no
// result. Tick and start items give one result on the output
// channel (out_valid_o / out_stall_i): found, switch_needed, next VM and vCPU and
// the timer reload value.
// A tick or start walks the slot memory one entry per cycle through its read
// port, with the check of each entry in the cycle after its read. A scan ends
// on the first runnable entry or once it has checked every filled entry; the
// result then passes the done state into the output register. An empty table
// skips the scan. The block takes one item at a time: in_stall_o is high from the
// transfer of a tick or start until its result is in the output register.
// A result waits in the output register while out_stall_i is high; the next
// item is still taken, and a later result holds in its last step until the
// output register is free.
// Reset empties the slot table, clears all VM and vCPU flags, drops the
// current vCPU and loads major_frame_us with 10000. The slot memory itself is
// not cleared; only entries below the fill count are ever read.
// cfg_we_i writes major_frame_us in the cycle it is high.
module time_partition_slot_scheduler #(
  parameter int NUM_VMS      = tpss_pkg::NUM_VMS_DEF,
  parameter int VCPUS_PER_VM = tpss_pkg::VCPUS_PER_VM_DEF,
  parameter int SLOT_DEPTH   = tpss_pkg::SLOT_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tpss_pkg::TIMER_W-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tpss_pkg::KIND_W-1:0]    kind_i,
  input  logic [tpss_pkg::VM_ID_W-1:0]   vm_ident_i,
  input  logic [tpss_pkg::VCPU_W-1:0]    vcpu_ident_i,
  input  logic [tpss_pkg::TIMER_W-1:0]   slice_us_i,
  input  logic                           vm_present_i,
  input  logic                           vm_running_i,
  input  logic [tpss_pkg::VCOUNT_W-1:0]  vcpu_count_i,
  input  logic                           stopped_flag_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           found_o,
  output logic                           switch_needed_o,
  output logic [tpss_pkg::VM_ID_W-1:0]   next_vm_o,
  output logic [tpss_pkg::VCPU_W-1:0]    next_vcpu_o,
  output logic [tpss_pkg::TIMER_W-1:0]   timer_us_o
);

  import tpss_pkg::*;

  localparam int IDX_W = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int CNT_W = $clog2(SLOT_DEPTH + 1);
  localparam int VM_W  = (NUM_VMS > 1) ? $clog2(NUM_VMS) : 1;
  localparam int ST_N  = NUM_VMS * VCPUS_PER_VM;
  localparam int ST_W  = (ST_N > 1) ? $clog2(ST_N) : 1;
  localparam int VC_W  = $clog2(VCPUS_PER_VM + 1);

  state_e             state_q, state_d;
  kind_e              kind;
  logic               in_acc;
  logic               load_out;

  logic [CNT_W-1:0]   slot_count_q;
  logic [IDX_W-1:0]   cur_slot_q;
  logic               cur_valid_q;
  logic [VM_ID_W-1:0] cur_vm_q;
  logic [VCPU_W-1:0]  cur_vcpu_q;
  logic [TIMER_W-1:0] major_q;

  logic               present_q [NUM_VMS];
  logic               running_q [NUM_VMS];
  logic [VC_W-1:0]    vcnt_q    [NUM_VMS];
  logic               stopped_q [ST_N];

  // Scan control
  logic [IDX_W-1:0]   addr_q;
  logic [CNT_W-1:0]   issued_q;
  logic [CNT_W-1:0]   evaled_q;
  logic               evalv_q;
  logic [IDX_W-1:0]   eval_addr_q;
  logic               start_mode_q;
  logic               issue;
  logic               scan_hit;
  logic               scan_end;

  // Pending result
  logic               res_found_q;
  logic               res_sw_q;
  logic [VM_ID_W-1:0] res_vm_q;
  logic [VCPU_W-1:0]  res_vcpu_q;
  logic [TIMER_W-1:0] res_timer_q;

  logic               out_valid_q;

  // Memory ports
  logic               ram_we;
  slot_t              ram_wdata;
  logic [$bits(slot_t)-1:0] ram_rdata;
  slot_t              rd_slot;

  // Entry checks
  logic               rd_vm_in;
  logic [VM_W-1:0]    rd_vm_idx;
  logic [ST_W-1:0]    rd_st_idx;
  logic               rd_ok;
  logic               rd_sw;
  logic               wr_vm_in;
  logic               wr_vc_in;
  logic [VM_W-1:0]    wr_vm_idx;
  logic [ST_W-1:0]    wr_st_idx;
  logic [VC_W-1:0]    wr_cnt;
  logic [IDX_W-1:0]   tick_first;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] s;
    s = CNT_W'(a) + CNT_W'(1);
    return (s == cnt) ? '0 : IDX_W'(s);
  endfunction

  assign kind   = kind_e'(kind_i);
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // Slot table write on add
  assign ram_we = in_acc && (kind == KIND_ADD_SLOT) && (32'(slot_count_q) < SLOT_DEPTH);
  assign ram_wdata.vm   = vm_ident_i;
  assign ram_wdata.vcpu = vcpu_ident_i;
  assign ram_wdata.dur  = (slice_us_i == '0) ? DEFAULT_SLICE_US : slice_us_i;

  assign issue = (state_q == ST_SCAN) && (issued_q < slot_count_q);

  tpss_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IDX_W'(slot_count_q)),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign rd_slot = slot_t'(ram_rdata);

  // Check the entry read in the last cycle
  always_comb begin
    rd_vm_in  = (32'(rd_slot.vm) < NUM_VMS);
    rd_vm_idx = VM_W'(rd_slot.vm);
    rd_st_idx = ST_W'(32'(rd_vm_idx) * VCPUS_PER_VM + 32'(rd_slot.vcpu));
    rd_ok     = rd_vm_in && present_q[rd_vm_idx] && running_q[rd_vm_idx] &&
                (32'(rd_slot.vcpu) < 32'(vcnt_q[rd_vm_idx])) &&
                (start_mode_q || !stopped_q[rd_st_idx]);
    rd_sw     = !cur_valid_q || (cur_vm_q != rd_slot.vm) || (cur_vcpu_q != rd_slot.vcpu);
  end

  // Decode status and stopped writes
  always_comb begin
    wr_vm_in  = (32'(vm_ident_i) < NUM_VMS);
    wr_vc_in  = (32'(vcpu_ident_i) < VCPUS_PER_VM);
    wr_vm_idx = VM_W'(vm_ident_i);
    wr_st_idx = ST_W'(32'(wr_vm_idx) * VCPUS_PER_VM + 32'(vcpu_ident_i));
    wr_cnt    = (32'(vcpu_count_i) > VCPUS_PER_VM) ? VC_W'(VCPUS_PER_VM)
                                                   : VC_W'(vcpu_count_i);
  end

  assign tick_first = wrap_inc(cur_slot_q, slot_count_q);
  assign scan_hit   = (state_q == ST_SCAN) && evalv_q && rd_ok;
  assign scan_end   = (state_q == ST_SCAN) && evalv_q && !rd_ok &&
                      ((evaled_q + CNT_W'(1)) == slot_count_q);
  assign load_out   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && ((kind == KIND_TICK) || (kind == KIND_START))) begin
          state_d = (slot_count_q == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Register file, table fill and current vCPU
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= '0;
      cur_slot_q   <= '0;
      cur_valid_q  <= 1'b0;
      cur_vm_q     <= '0;
      cur_vcpu_q   <= '0;
      major_q      <= MAJOR_FRAME_RESET;
      for (int i = 0; i < NUM_VMS; i++) begin
        present_q[i] <= 1'b0;
        running_q[i] <= 1'b0;
        vcnt_q[i]    <= '0;
      end
      for (int i = 0; i < ST_N; i++) begin
        stopped_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        major_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        slot_count_q <= slot_count_q + CNT_W'(1);
      end
      if (in_acc && (kind == KIND_VM_STATUS) && wr_vm_in) begin
        present_q[wr_vm_idx] <= vm_present_i;
        running_q[wr_vm_idx] <= vm_running_i;
        vcnt_q[wr_vm_idx]    <= wr_cnt;
      end
      if (in_acc && (kind == KIND_VCPU_STOP) && wr_vm_in && wr_vc_in) begin
        stopped_q[wr_st_idx] <= stopped_flag_i;
      end
      // Take the chosen slot; a start also wakes its vCPU
      if (scan_hit) begin
        cur_slot_q  <= eval_addr_q;
        cur_valid_q <= 1'b1;
        cur_vm_q    <= rd_slot.vm;
        cur_vcpu_q  <= rd_slot.vcpu;
        if (start_mode_q) begin
          stopped_q[rd_st_idx] <= 1'b0;
        end
      end
    end
  end

  // Scan counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= '0;
      issued_q     <= '0;
      evaled_q     <= '0;
      evalv_q      <= 1'b0;
      start_mode_q <= 1'b0;
    end else if (state_q == ST_IDLE) begin
      addr_q       <= (kind == KIND_START) ? '0 : tick_first;
      issued_q     <= '0;
      evaled_q     <= '0;
      evalv_q      <= 1'b0;
      start_mode_q <= (kind == KIND_START);
    end else if (state_q == ST_SCAN) begin
      evalv_q <= issue;
      if (issue) begin
        addr_q   <= wrap_inc(addr_q, slot_count_q);
        issued_q <= issued_q + CNT_W'(1);
      end
      if (evalv_q) begin
        evaled_q <= evaled_q + CNT_W'(1);
      end
    end else begin
      evalv_q <= 1'b0;
    end
  end

  // Address of the entry under check
  always_ff @(posedge clk_i) begin
    if (issue) begin
      eval_addr_q <= addr_q;
    end
  end

  // Capture the result of the scan
  always_ff @(posedge clk_i) begin
    if (scan_hit) begin
      res_found_q <= 1'b1;
      res_sw_q    <= rd_sw;
      res_vm_q    <= rd_slot.vm;
      res_vcpu_q  <= rd_slot.vcpu;
      res_timer_q <= rd_slot.dur;
    end else if (scan_end || (state_q == ST_IDLE)) begin
      res_found_q <= 1'b0;
      res_sw_q    <= 1'b0;
      res_vm_q    <= cur_vm_q;
      res_vcpu_q  <= cur_vcpu_q;
      res_timer_q <= major_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      found_o         <= res_found_q;
      switch_needed_o <= res_sw_q;
      next_vm_o       <= res_vm_q;
      next_vcpu_o     <= res_vcpu_q;
      timer_us_o      <= res_timer_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Assertions
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_count_q) <= SLOT_DEPTH)
    else $error("slot count beyond table depth");

  a_cur_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_count_q != '0) |-> (CNT_W'(cur_slot_q) < slot_count_q))
    else $error("current slot outside filled table");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (evaled_q < slot_count_q))
    else $error("scan checked more slots than the table holds");

  a_found_has_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> cur_valid_q)
    else $error("found result without a current vCPU");

  a_empty_no_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_count_q == '0) |-> (state_q != ST_SCAN))
    else $error("scan started on an empty table");

endmodule

FILE: hw/rtl/tpss_ram.sv
module tpss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: dv/time_partition_slot_scheduler_tb.sv
module time_partition_slot_scheduler_tb;
  import tpss_pkg::*;

  localparam int NUM_VMS      = NUM_VMS_DEF;
  localparam int VCPUS_PER_VM = VCPUS_PER_VM_DEF;
  localparam int SLOT_DEPTH   = SLOT_DEPTH_DEF;

  // Kinds the block must ignore
  localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 3'd5;
  localparam logic [KIND_W-1:0] KIND_LAST_UNUSED  = 3'd7;

  // Longest scan plus margin; also the quiet time before a frame write
  localparam int SETTLE_CYCLES = SLOT_DEPTH + 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [VM_ID_W-1:0]  vm;
    logic [VCPU_W-1:0]   vcpu;
    logic [TIMER_W-1:0]  slice;
    logic                present;
    logic                running;
    logic [VCOUNT_W-1:0] count;
    logic                stopped;
  } sched_item_t;

  typedef struct packed {
    logic               found;
    logic               sw;
    logic [VM_ID_W-1:0] vm;
    logic [VCPU_W-1:0]  vcpu;
    logic [TIMER_W-1:0] timer;
  } decision_t;

  typedef struct packed {
    sched_item_t item;
    logic        typed;
    decision_t   want;
  } directed_row_t;

  localparam int N_DIRECTED = 25;
  localparam decision_t NO_WANT = '0;
  localparam logic [TIMER_W-1:0] ALL_ONES = '1;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [TIMER_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [KIND_W-1:0]  kind_i = KIND_ADD_SLOT;
  logic [VM_ID_W-1:0] vm_ident_i = '0;
  logic [VCPU_W-1:0]  vcpu_ident_i = '0;
  logic [TIMER_W-1:0] slice_us_i = '0;
  logic               vm_present_i = 1'b0;
  logic               vm_running_i = 1'b0;
  logic [VCOUNT_W-1:0] vcpu_count_i = '0;
  logic               stopped_flag_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               found_o;
  logic               switch_needed_o;
  logic [VM_ID_W-1:0] next_vm_o;
  logic [VCPU_W-1:0]  next_vcpu_o;
  logic [TIMER_W-1:0] timer_us_o;

  time_partition_slot_scheduler u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .vm_ident_i      (vm_ident_i),
    .vcpu_ident_i    (vcpu_ident_i),
    .slice_us_i      (slice_us_i),
    .vm_present_i    (vm_present_i),
    .vm_running_i    (vm_running_i),
    .vcpu_count_i    (vcpu_count_i),
    .stopped_flag_i  (stopped_flag_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .switch_needed_o (switch_needed_o),
    .next_vm_o       (next_vm_o),
    .next_vcpu_o     (next_vcpu_o),
    .timer_us_o      (timer_us_o)
  );

  // Scheduler state as the testbench sees it
  logic [VM_ID_W-1:0] slot_vm    [SLOT_DEPTH];
  logic [VCPU_W-1:0]  slot_vcpu  [SLOT_DEPTH];
  logic [TIMER_W-1:0] slot_dur   [SLOT_DEPTH];
  int                 slot_fill = 0;
  int                 cur_slot = 0;
  logic               vm_up      [NUM_VMS] = '{default: 1'b0};
  logic               vm_run     [NUM_VMS] = '{default: 1'b0};
  int                 vm_ncpu    [NUM_VMS] = '{default: 0};
  logic               cpu_halted [NUM_VMS*VCPUS_PER_VM] = '{default: 1'b0};
  logic [VM_ID_W-1:0] run_vm = '0;
  logic [VCPU_W-1:0]  run_vcpu = '0;
  logic               run_valid = 1'b0;
  logic [TIMER_W-1:0] frame_us = MAJOR_FRAME_RESET;

  decision_t pending_decisions[$];
  int        fault_count = 0;
  int        cycle_count = 0;
  int        in_idle_pct = 30;
  int        out_idle_pct = 71;

  // Short walk through the special cases; reset frame value throughout
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{'{KIND_TICK, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, MAJOR_FRAME_RESET}},
    '{'{KIND_START, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, MAJOR_FRAME_RESET}},
    '{'{KIND_FIRST_UNUSED, 7, 3, ALL_ONES, 1, 1, 7, 1}, 0, NO_WANT},
    '{'{KIND_LAST_UNUSED, 0, 0, 0, 0, 0, 0, 0}, 0, NO_WANT},
    '{'{KIND_ADD_SLOT, 7, 3, 0, 0, 0, 0, 0}, 0, NO_WANT},
    '{'{KIND_ADD_SLOT, 0, 0, ALL_ONES, 1, 1, 7, 1}, 0, NO_WANT},
    '{'{KIND_TICK, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, MAJOR_FRAME_RESET}},
    '{'{KIND_VM_STATUS, 7, 0, 0, 1, 1, 7, 0}, 0, NO_WANT},
    '{'{KIND_VCPU_STOP, 7, 3, 0, 0, 0, 0, 1}, 0, NO_WANT},
    '{'{KIND_TICK, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, MAJOR_FRAME_RESET}},
    '{'{KIND_START, 0, 0, 0, 0, 0, 0, 0}, 0, NO_WANT},
    '{'{KIND_TICK, 0, 0, 0, 0, 0, 0, 0}, 0, NO_WANT},
    '{'{KIND_VM_STATUS, 0, 0, 0, 1, 0, 1, 0}, 0, NO_WANT},
    '{'{KIND_TICK, 0, 0, 0, 0, 0, 0, 0}, 0, NO_WANT},
    '{'{KIND_VM_STATUS, 0, 0, 0, 1, 1, 1, 0}, 0, NO_WANT},
    '{'{KIND_TICK, 0, 0, 0, 0, 0, 0, 0}, 1, '{1, 1, 0, 0, ALL_ONES}},
    '{'{KIND_VM_STATUS, 0, 0, 0, 0, 1, 4, 0}, 0, NO_WANT},
    '{'{KIND_ADD_SLOT, 7, 2, 5, 0, 0, 0, 0}, 0, NO_WANT},
    '{'{KIND_VM_STATUS, 7, 0, 0, 1, 1, 3, 0}, 0, NO_WANT},
    '{'{KIND_TICK, 0, 0, 0, 0, 0, 0, 0}, 0, NO_WANT},
    '{'{KIND_VCPU_STOP, 7, 2, 0, 0, 0, 0, 1}, 0, NO_WANT},
    '{'{KIND_TICK, 0, 0, 0, 0, 0, 0, 0}, 0, NO_WANT},
    '{'{KIND_VCPU_STOP, 7, 2, 0, 0, 0, 0, 0}, 0, NO_WANT},
    '{'{KIND_START, 0, 0, 0, 0, 0, 0, 0}, 0, NO_WANT},
    '{'{KIND_VCPU_STOP, 0, 1, 0, 0, 0, 0, 1}, 0, NO_WANT}
  };

  // Runnable check for one slot; start ignores the stopped flags
  function automatic logic slot_runnable(int s, logic honor_stop);
    int v;
    int c;
    v = int'(slot_vm[s]);
    c = int'(slot_vcpu[s]);
    if (!vm_up[v] || !vm_run[v]) return 1'b0;
    if (c >= vm_ncpu[v]) return 1'b0;
    if (honor_stop && cpu_halted[v*VCPUS_PER_VM + c]) return 1'b0;
    return 1'b1;
  endfunction

  // Make slot s current and tell whether the running vCPU changes
  function automatic logic take_slot(int s);
    logic sw;
    sw = !run_valid || run_vm != slot_vm[s] || run_vcpu != slot_vcpu[s];
    cur_slot  = s;
    run_vm    = slot_vm[s];
    run_vcpu  = slot_vcpu[s];
    run_valid = 1'b1;
    return sw;
  endfunction

  // Apply one transferred item to the scheduler state and work out its decision
  function automatic void schedule_item(input sched_item_t it, output logic has,
                                        output decision_t d);
    int   s;
    logic hit;
    logic sw;
    has = 1'b0;
    hit = 1'b0;
    sw  = 1'b0;
    s   = 0;
    d   = '0;
    case (it.kind)
      KIND_ADD_SLOT: begin
        if (slot_fill < SLOT_DEPTH) begin
          slot_vm[slot_fill]   = it.vm;
          slot_vcpu[slot_fill] = it.vcpu;
          slot_dur[slot_fill]  = (it.slice == '0) ? DEFAULT_SLICE_US : it.slice;
          slot_fill++;
        end
      end
      KIND_VM_STATUS: begin
        vm_up[it.vm]   = it.present;
        vm_run[it.vm]  = it.running;
        vm_ncpu[it.vm] = (int'(it.count) > VCPUS_PER_VM) ? VCPUS_PER_VM : int'(it.count);
      end
      KIND_VCPU_STOP: begin
        cpu_halted[int'(it.vm)*VCPUS_PER_VM + int'(it.vcpu)] = it.stopped;
      end
      KIND_TICK: begin
        has = 1'b1;
        s = cur_slot;
        for (int i = 0; i < slot_fill && !hit; i++) begin
          s = (s + 1) % slot_fill;
          if (slot_runnable(s, 1'b1)) begin
            hit = 1'b1;
            sw  = take_slot(s);
          end
        end
      end
      KIND_START: begin
        has = 1'b1;
        for (int i = 0; i < slot_fill && !hit; i++) begin
          if (slot_runnable(i, 1'b0)) begin
            hit = 1'b1;
            s   = i;
            sw  = take_slot(i);
            cpu_halted[int'(run_vm)*VCPUS_PER_VM + int'(run_vcpu)] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    d.found = hit;
    d.sw    = sw;
    d.vm    = run_vm;
    d.vcpu  = run_vcpu;
    d.timer = hit ? slot_dur[s] : frame_us;
  endfunction

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(input sched_item_t it, input logic typed, input decision_t want);
    logic      has;
    decision_t d;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= it.kind;
    vm_ident_i     <= it.vm;
    vcpu_ident_i   <= it.vcpu;
    slice_us_i     <= it.slice;
    vm_present_i   <= it.present;
    vm_running_i   <= it.running;
    vcpu_count_i   <= it.count;
    stopped_flag_i <= it.stopped;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    schedule_item(it, has, d);
    if (has) pending_decisions.push_back(typed ? want : d);
  endtask

  // Hold the input until every decision is out and the block has gone quiet
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_decisions.size() != 0) @(posedge clk_i);
  endtask

  // Program the major frame while the block is idle
  task automatic write_frame(input logic [TIMER_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    frame_us = value;
  endtask

  // Mostly well-formed traffic: ticks over a growing table with live VMs
  task automatic run_random(input int n_items, input int add_pct);
    sched_item_t it;
    int          pick;
    int          done;
    done = 0;
    while (done < n_items) begin
      it.vm      = VM_ID_W'($urandom);
      it.vcpu    = VCPU_W'($urandom);
      it.slice   = $urandom;
      it.present = ($urandom_range(3) != 0);
      it.running = ($urandom_range(3) != 0);
      it.count   = VCOUNT_W'($urandom);
      it.stopped = ($urandom_range(2) == 0);
      pick = $urandom_range(99);
      if (pick < add_pct) begin
        it.kind = KIND_ADD_SLOT;
        if ($urandom_range(9) == 0) it.slice = '0;
      end else if (pick < add_pct + 15) begin
        it.kind = KIND_VM_STATUS;
      end else if (pick < add_pct + 27) begin
        it.kind = KIND_VCPU_STOP;
      end else if (pick < 87) begin
        it.kind = KIND_TICK;
      end else if (pick < 95) begin
        it.kind = KIND_START;
      end else begin
        it.kind = KIND_FIRST_UNUSED + KIND_W'($urandom_range(2));
      end
      send_item(it, 1'b0, NO_WANT);
      if (it.kind <= KIND_START) done++;
      if ($urandom_range(99) == 0) drain();
    end
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Compare each transferred result with the oldest decision; drive receiver stalls
  always @(posedge clk_i) begin
    decision_t got;
    decision_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{found_o, switch_needed_o, next_vm_o, next_vcpu_o, timer_us_o};
      if (pending_decisions.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("unexpected result: found=%0b sw=%0b vm=%0d vcpu=%0d timer=%0d",
                   got.found, got.sw, got.vm, got.vcpu, got.timer);
      end else begin
        want = pending_decisions.pop_front();
        if (got.found !== want.found || got.sw !== want.sw || got.vm !== want.vm ||
            got.vcpu !== want.vcpu || got.timer !== want.timer) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("mismatch: exp found=%0b sw=%0b vm=%0d vcpu=%0d timer=%0d %s",
                     want.found, want.sw, want.vm, want.vcpu, want.timer,
                     $sformatf("got found=%0b sw=%0b vm=%0d vcpu=%0d timer=%0d",
                               got.found, got.sw, got.vm, got.vcpu, got.timer));
        end
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < out_idle_pct);
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk with the reset frame value
    for (int r = 0; r < N_DIRECTED; r++)
      send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);

    // Zero frame, sender idles lightly and receiver heavily
    write_frame('0);
    run_random(130, 10);

    // Largest frame, roles swapped
    in_idle_pct  = 71;
    out_idle_pct = 30;
    write_frame(ALL_ONES);
    run_random(130, 10);

    // Random frame, full rate on both sides; push the table past full
    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_frame($urandom);
    run_random(140, 25);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/tpss_pkg.sv
hw/rtl/tpss_ram.sv
hw/rtl/time_partition_slot_scheduler.sv
dv/time_partition_slot_scheduler_tb.sv
